// ===== src/mlps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mlps_pkg;

	localparam int ACC_W         = 40;
	localparam int PROD_W        = 33;
	localparam int SIG_N         = 1024;
	localparam int SIG_IDX_W     = 10;
	localparam int SIG_HALF      = 512;
	localparam int SIG_SHIFT_HID = 20;
	localparam int SIG_SHIFT_OUT = 21;
	localparam int QUEUE_DEPTH   = 4;
	localparam int PIX_IDX_W     = 10;
	localparam logic signed [16:0] ONE_Q14 = 17'sd16384;
	localparam logic signed [16:0] ONE_Q15 = 17'sd32768;
	localparam logic [63:0] EXP_STEP = 64'd2114190000;
	localparam logic signed [ACC_W-1:0] SIG_Q_MIN = -40'sd512;
	localparam logic signed [ACC_W-1:0] SIG_Q_MAX = 40'sd511;

	typedef struct packed {
		logic              req_type;
		logic [13:0]       weight_addr;
		logic signed [15:0] weight_value;
		logic signed [15:0] pixel_value;
		logic              last_pixel;
	} req_t;

	typedef struct packed {
		logic [3:0]  predicted_class;
		logic [15:0] best_score;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_PIX,
		CMD_PIX_LAST,
		CMD_LAST
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [13:0]        addr;
		logic signed [15:0] data;
		logic [PIX_IDX_W-1:0] pix_idx;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_beat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PIX,
		BK_FIN_A,
		BK_FIN_B,
		BK_DRAIN
	} bk_state_t;

	typedef enum logic [1:0] {
		TAG_HID_ACC,
		TAG_HID_FIN,
		TAG_OUT
	} tag_kind_t;

	typedef logic [15:0] sig_lut_t [SIG_N];

	function automatic sig_lut_t build_sig_lut();
		logic [63:0] t [513];
		logic [63:0] tv;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] rem;
		logic [47:0] quo;
		int k;
		sig_lut_t lut;
		t[0] = 64'd1 << 31;
		for (int m = 1; m <= 512; m++) begin
			t[m] = (t[m-1] * EXP_STEP + (64'd1 << 30)) >> 31;
		end
		for (int m = 0; m < SIG_N; m++) begin
			k = m - SIG_HALF;
			tv = t[(k >= 0) ? k : -k];
			den = (64'd1 << 31) + tv;
			num = ((k >= 0) ? (64'd1 << 46) : (tv << 15)) + (den >> 1);
			rem = '0;
			quo = '0;
			// restoring long division
			for (int i = 47; i >= 0; i--) begin
				rem = {rem[62:0], num[i]};
				if (rem >= den) begin
					rem = rem - den;
					quo[i] = 1'b1;
				end
			end
			lut[m] = quo[15:0];
		end
		return lut;
	endfunction

	localparam sig_lut_t SIG_LUT = build_sig_lut();

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0]  a,
		input logic signed [PROD_W-1:0] p
	);
		logic signed [ACC_W:0] s;
		s = (ACC_W+1)'(a) + (ACC_W+1)'(p);
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end
		return s[ACC_W-1:0];
	endfunction

	function automatic logic [SIG_IDX_W-1:0] sig_index(
		input logic signed [ACC_W-1:0] s,
		input logic                    out_layer
	);
		logic signed [ACC_W-1:0] q;
		q = out_layer ? (s >>> SIG_SHIFT_OUT) : (s >>> SIG_SHIFT_HID);
		if (q < SIG_Q_MIN) begin
			return '0;
		end
		if (q > SIG_Q_MAX) begin
			return '1;
		end
		return q[SIG_IDX_W-1:0] + SIG_IDX_W'(SIG_HALF);
	endfunction

endpackage
`default_nettype wire

// ===== src/mlps_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mlps_front import mlps_pkg::*; #(
	parameter int N_IN    = 400,
	parameter int W_TOTAL = 10285
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_stall,
	input  wire req_t    req,
	output q_beat_t      push,
	input  wire logic    q_full
);

	localparam int CW = $clog2(N_IN + 1);

	logic [CW-1:0] pix_cnt_q;
	logic          accept;
	logic          is_wr;
	logic          in_rng;
	logic          has_pix;
	logic          emit;
	logic [31:0]   cnt_wide;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;
	assign is_wr     = !req.req_type;
	assign in_rng    = 32'(req.weight_addr) < W_TOTAL;
	assign has_pix   = pix_cnt_q < CW'(N_IN);
	assign emit      = is_wr ? in_rng : (req.last_pixel || has_pix);
	assign cnt_wide  = 32'(pix_cnt_q);

	always_comb begin
		push.valid        = accept && emit;
		push.cmd.addr     = req.weight_addr;
		push.cmd.data     = is_wr ? req.weight_value : req.pixel_value;
		push.cmd.pix_idx  = cnt_wide[PIX_IDX_W-1:0];
		if (is_wr) begin
			push.cmd.kind = CMD_WRITE;
		end else if (req.last_pixel) begin
			push.cmd.kind = has_pix ? CMD_PIX_LAST : CMD_LAST;
		end else begin
			push.cmd.kind = CMD_PIX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cnt_q <= '0;
		end else if (accept && !is_wr) begin
			if (req.last_pixel) begin
				pix_cnt_q <= '0;
			end else if (has_pix) begin
				pix_cnt_q <= pix_cnt_q + CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/mlps_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mlps_queue import mlps_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_beat_t push,
	output logic         full,
	output q_beat_t      head,
	input  wire logic    pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [PW:0]   count_q;

	assign full       = count_q == (PW+1)'(QUEUE_DEPTH);
	assign head.valid = count_q != '0;
	assign head.cmd   = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/mlps_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mlps_back import mlps_pkg::*; #(
	parameter int N_IN  = 400,
	parameter int N_HID = 25,
	parameter int N_OUT = 10
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_beat_t head,
	output logic         pop,
	output logic         rsp_valid,
	input  wire logic    rsp_stall,
	output rsp_t         rsp
);

	localparam int HID_ROW  = N_IN + 1;
	localparam int OUT_ROW  = N_HID + 1;
	localparam int OUT_BASE = N_HID * HID_ROW;
	localparam int W_TOTAL  = OUT_BASE + N_OUT * OUT_ROW;
	localparam int AW       = $clog2(W_TOTAL);
	localparam int HW       = (N_HID > 1) ? $clog2(N_HID) : 1;
	localparam int JW       = $clog2(N_HID + 1);
	localparam int OW       = $clog2(N_OUT);

	bk_state_t state_q, state_d;

	logic [15:0]        wmem [W_TOTAL];
	logic signed [ACC_W-1:0] hsum_q [N_HID];
	logic [15:0]        act_q [N_HID];

	logic [JW-1:0]      j_q;
	logic [OW-1:0]      o_q;
	logic               fin_pend_q;
	logic [AW-1:0]      addr_q;
	logic signed [15:0] px_q;

	logic               we;
	logic               re;
	tag_kind_t          tag_kind;
	logic signed [16:0] tag_b;
	logic [AW-1:0]      waddr;
	logic [31:0]        addr_wide;
	logic [31:0]        idx_wide;
	logic               h_last;
	logic               j_last;
	logic               o_last;
	logic               pop_fin;

	logic               v_s1;
	tag_kind_t          kind_s1;
	logic [JW-1:0]      j_s1;
	logic [OW-1:0]      o_s1;
	logic signed [16:0] b_s1;
	logic signed [15:0] w_s1;
	logic signed [16:0] b_mux;
	logic [JW-1:0]      jm1;
	logic signed [PROD_W-1:0] prod_d;

	logic               v_s2;
	tag_kind_t          kind_s2;
	logic [JW-1:0]      j_s2;
	logic [OW-1:0]      o_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [HW-1:0]      hidx2;
	logic signed [ACC_W-1:0] hid_sum_d;
	logic signed [ACC_W-1:0] out_sum_d;
	logic signed [ACC_W-1:0] acc_q;

	logic               fin_v_s3;
	logic signed [ACC_W-1:0] fin_sum_s3;
	logic [OW-1:0]      fin_o_s3;
	logic [15:0]        act_out;
	logic               take;
	logic [15:0]        new_val;
	logic [OW-1:0]      new_cls;
	logic               res_done;
	logic [15:0]        best_val_q;
	logic [OW-1:0]      best_cls_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	assign h_last    = j_q == JW'(N_HID - 1);
	assign j_last    = j_q == JW'(N_HID);
	assign o_last    = o_q == OW'(N_OUT - 1);
	assign pop_fin   = head.cmd.kind == CMD_PIX_LAST || head.cmd.kind == CMD_LAST;
	assign addr_wide = 32'(head.cmd.addr);
	assign waddr     = addr_wide[AW-1:0];
	assign idx_wide  = 32'(head.cmd.pix_idx) + 32'd1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					if (head.cmd.kind == CMD_PIX || head.cmd.kind == CMD_PIX_LAST) begin
						state_d = BK_PIX;
					end else if (head.cmd.kind == CMD_LAST) begin
						state_d = BK_FIN_A;
					end
				end
			end
			BK_PIX: begin
				if (h_last) begin
					state_d = fin_pend_q ? BK_FIN_A : BK_IDLE;
				end
			end
			BK_FIN_A: begin
				if (h_last) begin
					state_d = BK_FIN_B;
				end
			end
			BK_FIN_B: begin
				if (j_last && o_last) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				if (res_done) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop      = 1'b0;
		we       = 1'b0;
		re       = 1'b0;
		tag_kind = TAG_HID_ACC;
		tag_b    = 17'(px_q);
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					if (head.cmd.kind == CMD_WRITE) begin
						pop = 1'b1;
						we  = 1'b1;
					end else if (!pop_fin || !rsp_valid_q) begin
						// a finish waits until the last result is taken
						pop = 1'b1;
					end
				end
			end
			BK_PIX: begin
				re = 1'b1;
			end
			BK_FIN_A: begin
				re       = 1'b1;
				tag_kind = TAG_HID_FIN;
				tag_b    = ONE_Q14;
			end
			BK_FIN_B: begin
				re       = 1'b1;
				tag_kind = TAG_OUT;
				tag_b    = ONE_Q15;
			end
			BK_DRAIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			j_q        <= '0;
			o_q        <= '0;
			fin_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && !we) begin
				j_q        <= '0;
				o_q        <= '0;
				fin_pend_q <= head.cmd.kind == CMD_PIX_LAST;
			end else if (state_q == BK_PIX || state_q == BK_FIN_A) begin
				j_q <= h_last ? '0 : j_q + JW'(1);
			end else if (state_q == BK_FIN_B) begin
				if (j_last) begin
					j_q <= '0;
					o_q <= o_q + OW'(1);
				end else begin
					j_q <= j_q + JW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && !we) begin
			px_q   <= head.cmd.data;
			addr_q <= (head.cmd.kind == CMD_LAST) ? '0 : idx_wide[AW-1:0];
		end else if (state_q == BK_PIX) begin
			addr_q <= h_last ? '0 : addr_q + AW'(HID_ROW);
		end else if (state_q == BK_FIN_A) begin
			addr_q <= h_last ? AW'(OUT_BASE) : addr_q + AW'(HID_ROW);
		end else if (state_q == BK_FIN_B) begin
			// output rows sit back to back
			addr_q <= addr_q + AW'(1);
		end
	end

	// weight store, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			wmem[waddr] <= head.cmd.data;
		end
		if (re) begin
			w_s1 <= wmem[addr_q];
		end
	end

	// stage 1: operand select and multiply
	assign jm1   = j_s1 - JW'(1);
	assign b_mux = (kind_s1 == TAG_OUT && j_s1 != '0) ? {1'b0, act_q[jm1[HW-1:0]]} : b_s1;
	assign prod_d = PROD_W'(w_s1) * PROD_W'(b_mux);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			fin_v_s3 <= 1'b0;
		end else begin
			v_s1     <= re;
			v_s2     <= v_s1;
			fin_v_s3 <= v_s2 && kind_s2 == TAG_OUT && j_s2 == JW'(N_HID);
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= tag_kind;
		j_s1    <= j_q;
		o_s1    <= o_q;
		b_s1    <= tag_b;
		kind_s2 <= kind_s1;
		j_s2    <= j_s1;
		o_s2    <= o_s1;
		prod_s2 <= prod_d;
	end

	// stage 2: accumulate
	assign hidx2     = j_s2[HW-1:0];
	assign hid_sum_d = sat_add(hsum_q[hidx2], prod_s2);
	assign out_sum_d = (j_s2 == '0) ? ACC_W'(prod_s2) : sat_add(acc_q, prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_HID; i++) begin
				hsum_q[i] <= '0;
			end
		end else if (v_s2) begin
			if (kind_s2 == TAG_HID_ACC) begin
				hsum_q[hidx2] <= hid_sum_d;
			end else if (kind_s2 == TAG_HID_FIN) begin
				hsum_q[hidx2] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && kind_s2 == TAG_HID_FIN) begin
			act_q[hidx2] <= SIG_LUT[sig_index(hid_sum_d, 1'b0)];
		end
		if (v_s2 && kind_s2 == TAG_OUT) begin
			acc_q <= out_sum_d;
		end
		fin_sum_s3 <= out_sum_d;
		fin_o_s3   <= o_s2;
	end

	// stage 3: output sigmoid and argmax
	assign act_out  = SIG_LUT[sig_index(fin_sum_s3, 1'b1)];
	assign take     = fin_o_s3 == '0 || act_out > best_val_q;
	assign new_val  = take ? act_out : best_val_q;
	assign new_cls  = take ? fin_o_s3 : best_cls_q;
	assign res_done = fin_v_s3 && fin_o_s3 == OW'(N_OUT - 1);

	always_ff @(posedge clk) begin
		if (fin_v_s3) begin
			best_val_q <= new_val;
			best_cls_q <= new_cls;
		end
		if (res_done) begin
			rsp_q.predicted_class <= 4'(new_cls);
			rsp_q.best_score      <= new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_done |-> !rsp_valid_q)
		else $error("result overwrites a pending beat");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		res_done |=> rsp_valid_q)
		else $error("finished image gave no result beat");

	a_out_layer_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && kind_s1 == TAG_OUT) |-> (state_q == BK_FIN_B || state_q == BK_DRAIN))
		else $error("output layer work outside its phase");

endmodule
`default_nettype wire

// ===== src/mlp_sigmoid_inference.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Two-layer perceptron classifier (N_IN inputs, N_HID sigmoid hidden units, N_OUT sigmoid
// outputs). Weight beats fill the weight store; pixel beats stream an image and a beat with
// last_pixel returns the winning class and its Q1.15 score. A front end counts pixels and
// queues work in a four-entry queue, so the input keeps accepting while the engine runs
// until that queue is full; a beat that ends an image waits in the queue while a result is
// still held, and the input stalls once the queue fills behind it. The engine reads one
// weight per cycle from the single weight store port while it works on a beat, and takes
// the next beat from the queue only once idle again: a weight beat is written to the store,
// a pixel reads one weight per hidden unit, and the end of an image reads the hidden biases
// and then every output-layer weight; the result is registered after the argmax stage.
// Every weight used must have been written before the image is sent.
module mlp_sigmoid_inference import mlps_pkg::*; #(
	parameter int N_IN  = 400,
	parameter int N_HID = 25,
	parameter int N_OUT = 10
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	localparam int W_TOTAL = N_HID * (N_IN + 1) + N_OUT * (N_HID + 1);

	q_beat_t push;
	q_beat_t head;
	logic    q_full;
	logic    pop;

	mlps_front #(
		.N_IN    (N_IN),
		.W_TOTAL (W_TOTAL)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.push      (push),
		.q_full    (q_full)
	);

	mlps_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	mlps_back #(
		.N_IN  (N_IN),
		.N_HID (N_HID),
		.N_OUT (N_OUT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ===== bench/tb_mlp_sigmoid_inference.sv =====
`timescale 1ns / 1ps
module tb_mlp_sigmoid_inference;
	import mlps_pkg::*;

	localparam int NI = 400;
	localparam int NH = 25;
	localparam int NO = 10;
	localparam int HROW = NI + 1;
	localparam int OROW = NH + 1;
	localparam int OBASE = NH * HROW;
	localparam int WTOTAL = OBASE + NO * OROW;
	localparam longint SUM_MAX = 64'sd549755813887;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 400;

	typedef struct {
		req_t beat;
		bit   hold;
	} pend_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	mlp_sigmoid_inference DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #2 clk = ~clk;

	logic [15:0] act_lut [1024];
	int wts [WTOTAL];
	longint hsum [NH];
	int npix;
	rsp_t score_q [$];
	pend_t pend [$];
	int errors = 0;
	int n_items = 0;
	int n_images = 0;

	function automatic longint clip_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > SUM_MAX) return SUM_MAX;
		if (s < SUM_MIN) return SUM_MIN;
		return s;
	endfunction

	function automatic logic [15:0] squash(longint s, int sh);
		longint q;
		q = (s >>> sh) + 512;
		if (q < 0) q = 0;
		if (q > 1023) q = 1023;
		return act_lut[q];
	endfunction

	// updates the mirrored network state and queues the class the beat should produce
	task automatic classify(req_t b);
		logic [15:0] acts [NH];
		longint s;
		logic [15:0] a;
		logic [15:0] top;
		int win;
		rsp_t r;
		if (!b.req_type) begin
			if (b.weight_addr < WTOTAL) wts[b.weight_addr] = int'(b.weight_value);
			return;
		end
		if (npix < NI) begin
			for (int h = 0; h < NH; h++)
				hsum[h] = clip_add(hsum[h],
					longint'(wts[h*HROW+1+npix]) * longint'($signed(b.pixel_value)));
			npix++;
		end
		if (!b.last_pixel) return;
		for (int h = 0; h < NH; h++)
			acts[h] = squash(clip_add(hsum[h], longint'(wts[h*HROW]) * 16384), 20);
		top = '0;
		win = 0;
		for (int o = 0; o < NO; o++) begin
			s = longint'(wts[OBASE+o*OROW]) * 32768;
			for (int h = 0; h < NH; h++)
				s = clip_add(s, longint'(wts[OBASE+o*OROW+1+h]) * longint'(acts[h]));
			a = squash(s, 21);
			if (o == 0 || a > top) begin
				top = a;
				win = o;
			end
		end
		for (int h = 0; h < NH; h++) hsum[h] = 0;
		npix = 0;
		r.predicted_class = 4'(win);
		r.best_score = top;
		score_q.push_back(r);
	endtask

	task automatic push_beat(req_t b, bit hold = 1'b0);
		pend_t p;
		p.beat = b;
		p.hold = hold;
		pend.push_back(p);
		n_items++;
	endtask

	task automatic push_weight(int addr, int val, bit hold = 1'b0);
		req_t b;
		b = '0;
		b.req_type = 1'b0;
		b.weight_addr = 14'(addr);
		b.weight_value = 16'(val);
		b.pixel_value = 16'($urandom);
		b.last_pixel = 1'($urandom);
		push_beat(b, hold);
	endtask

	task automatic push_pixel(int val, bit last);
		req_t b;
		b = '0;
		b.req_type = 1'b1;
		b.weight_addr = 14'($urandom);
		b.weight_value = 16'($urandom);
		b.pixel_value = 16'(val);
		b.last_pixel = last;
		push_beat(b);
	endtask

	function automatic int rand_pixel();
		case ($urandom_range(0, 7))
			0: return 32767;
			1: return -32768;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	task automatic push_image(int len);
		for (int i = 0; i < len; i++) push_pixel(rand_pixel(), i == len - 1);
		n_images++;
	endtask

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// sender
	bit tx_live;
	bit tx_burst = 1'b0;
	int tx_gap = 0;
	pend_t tx_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			tx_gap = 0;
		end else begin
			tx_live = req_valid;
			if (req_valid && !req_stall) begin
				classify(req);
				tx_live = 1'b0;
				if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
				tx_gap = tx_burst ? 0 : $urandom_range(0, 10);
			end
			if (!tx_live) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pend.size() != 0 && !(pend[0].hold && score_q.size() != 0)) begin
					tx_next = pend.pop_front();
					tx_live = 1'b1;
					req <= tx_next.beat;
				end
			end
			req_valid <= tx_live;
		end
	end

	// receiver
	bit rx_burst = 1'b0;
	int rx_cnt = 0;
	int rx_done = 0;
	rsp_t rx_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			rx_cnt = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (score_q.size() == 0) begin
					report("unexpected result, class", rsp.predicted_class, -1);
				end else begin
					rx_want = score_q.pop_front();
					if (rsp.predicted_class !== rx_want.predicted_class)
						report("predicted_class", rsp.predicted_class, rx_want.predicted_class);
					if (rsp.best_score !== rx_want.best_score)
						report("best_score", rsp.best_score, rx_want.best_score);
				end
				rx_done++;
				if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
				// one long hold-off so the input queue backs up
				if (rx_done == 20) rx_cnt = 600;
				else rx_cnt = rx_burst ? 0 : $urandom_range(0, 10);
			end else if (rx_cnt > 0) begin
				rx_cnt--;
			end
			rsp_stall <= (rx_cnt > 0);
		end
	end

	int quiet = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
			else quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles", STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	int r;
	int len;
	longint t [513];
	longint tv;
	longint den;
	longint num;

	initial begin
		t[0] = 64'sd1 <<< 31;
		for (int m = 1; m <= 512; m++) t[m] = (t[m-1] * 2114190000 + (64'sd1 <<< 30)) >>> 31;
		for (int m = 0; m < 1024; m++) begin
			tv = t[(m >= 512) ? m - 512 : 512 - m];
			den = (64'sd1 <<< 31) + tv;
			num = (m >= 512) ? (64'sd1 <<< 46) : (tv <<< 15);
			act_lut[m] = 16'((num + den / 2) / den);
		end
		for (int i = 0; i < WTOTAL; i++) wts[i] = 0;
		for (int h = 0; h < NH; h++) hsum[h] = 0;
		npix = 0;

		// full weight load so no image ever reads an unwritten entry
		for (int i = 0; i < WTOTAL; i++) push_weight(i, int'($signed(16'($urandom))));

		// directed: extremes, out-of-range writes, clamping, ties, short and long images
		push_weight(0, 32767);
		push_weight(1, 32767);
		push_weight(WTOTAL - 1, -32768);
		push_weight(HROW + 1, -32768);
		push_weight(WTOTAL, 1234);
		push_weight(16383, -1);
		push_pixel(32767, 1'b1);
		push_pixel(-32768, 1'b1);
		push_pixel(0, 1'b0);
		push_pixel(-1, 1'b1);
		n_images += 3;
		// every output row zeroed: all scores equal, first class wins
		for (int i = OBASE; i < WTOTAL; i++) push_weight(i, 0);
		push_pixel(16384, 1'b1);
		n_images++;
		for (int i = OBASE; i < WTOTAL; i++) push_weight(i, int'($signed(16'($urandom))));
		push_image(NI);
		push_image(NI + 6);

		// random: mostly short images with weight updates mixed in
		while (n_items < WTOTAL + 2 * OROW * NO + 840 + 1650 || n_images < 60) begin
			r = $urandom_range(0, 9);
			if (r < 3) begin
				if ($urandom_range(0, 9) == 0) push_weight($urandom_range(WTOTAL, 16383), $urandom);
				else push_weight($urandom_range(0, WTOTAL - 1), int'($signed(16'($urandom))));
			end else if (r == 3) begin
				// for about one in four of these beats the sender waits for every result before sending it
				push_weight($urandom_range(OBASE, WTOTAL - 1), int'($signed(16'($urandom))),
					$urandom_range(0, 3) == 0);
			end else begin
				len = ($urandom_range(0, 14) == 0) ? $urandom_range(100, NI + 10)
					: $urandom_range(1, 20);
				push_image(len);
			end
		end
		push_weight(0, 1, 1'b1);
		push_image(5);

		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (pend.size() != 0 || req_valid || score_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && score_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
	end

endmodule

// ===== sim.f =====
src/mlps_pkg.sv
src/mlps_front.sv
src/mlps_queue.sv
src/mlps_back.sv
src/mlp_sigmoid_inference.sv
bench/tb_mlp_sigmoid_inference.sv
